[hw/rtl/ubfe_pkg.sv]
// shared constants for the uart buffered fifo engine
// opcodes and default fifo depths; no dependencies
package ubfe_pkg;

    localparam int TX_DEPTH_DEF   = 16;
    localparam int RX_DEPTH_DEF   = 16;
    localparam int MAX_BURST_READ = 16;

    localparam logic [2:0] OP_FLUSH    = 3'd0;
    localparam logic [2:0] OP_TX_PUT   = 3'd1;
    localparam logic [2:0] OP_TX_BURST = 3'd2;
    localparam logic [2:0] OP_RX_GET   = 3'd3;
    localparam logic [2:0] OP_RX_BURST = 3'd4;
    localparam logic [2:0] OP_SERVICE  = 3'd5;

endpackage

[hw/rtl/ubfe_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module ubfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/uart_buffered_fifo_engine.sv]
// uart buffered fifo engine: transmit and receive byte fifos with service step
// depends on ubfe_pkg and ubfe_ram
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------
//  request | i_in_valid / o_in_ready    | i_opcode .. i_line_errors
//  result  | o_out_valid / i_out_ready  | o_status .. o_error_total, o_last
//
// every request passes through accept, fifo ram read, then execute and load result.
// each further byte of a burst read goes back through the registered ram read and execute.
// a new request is taken while the last result still waits in its register;
// execution of the next one holds until that result is taken.
// synchronous active-low reset clears pointers, levels, counters and control.
module uart_buffered_fifo_engine
    import ubfe_pkg::*;
#(
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_data,
    input  logic [4:0]  i_burst_length,
    input  logic        i_burst_first,
    input  logic        i_tx_empty,
    input  logic        i_rx_ready,
    input  logic [3:0]  i_line_errors,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [7:0]  o_read_byte,
    output logic        o_send_valid,
    output logic [7:0]  o_send_byte,
    output logic        o_tx_irq_on,
    output logic        o_last,
    output logic [4:0]  o_tx_level,
    output logic [4:0]  o_rx_level,
    output logic [31:0] o_sent_total,
    output logic [31:0] o_received_total,
    output logic [31:0] o_error_total
);

    localparam int TAW  = $clog2(TX_DEPTH);
    localparam int RAW  = $clog2(RX_DEPTH);
    localparam int TCW  = $clog2(TX_DEPTH + 1);
    localparam int RCW  = $clog2(RX_DEPTH + 1);
    localparam int TCMW = (TCW > 5) ? TCW : 5;
    localparam int RCMW = (RCW > 5) ? RCW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    // control state
    logic [1:0]     r_state, n_state;
    logic [TAW-1:0] r_tx_wa, n_tx_wa, r_tx_ra, n_tx_ra;
    logic [RAW-1:0] r_rx_wa, n_rx_wa, r_rx_ra, n_rx_ra;
    logic [TCW-1:0] r_tx_cnt, n_tx_cnt;
    logic [RCW-1:0] r_rx_cnt, n_rx_cnt;
    logic           r_idle, n_idle;
    logic           r_ba, n_ba;
    logic [4:0]     r_bl, n_bl;
    logic           r_bact, n_bact;
    logic [4:0]     r_bcnt, n_bcnt;
    logic [31:0]    r_sent, n_sent, r_recv, n_recv, r_err, n_err;
    logic           r_ovalid, n_ovalid;

    // latched request
    logic [2:0] r_op;
    logic [7:0] r_data;
    logic [4:0] r_len;
    logic       r_first, r_txe, r_rxr, r_lerr;

    // result register
    logic        r_o_status, n_o_status;
    logic [7:0]  r_o_rbyte, n_o_rbyte;
    logic        r_o_sv, n_o_sv;
    logic [7:0]  r_o_sb, n_o_sb;
    logic        r_o_last, n_o_last;

    logic           w_accept, w_can_load, w_load;
    logic           w_tx_we, w_rx_we, w_rd_en;
    logic [7:0]     w_tx_rdata, w_rx_rdata;
    logic [TCW-1:0] w_tx_free;
    logic [4:0]     w_left;
    logic           w_burst_ok, w_bread_ok;

    ubfe_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (w_tx_we),
        .i_waddr (r_tx_wa),
        .i_wdata (r_data),
        .i_re    (w_rd_en),
        .i_raddr (r_tx_ra),
        .o_rdata (w_tx_rdata)
    );

    ubfe_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (w_rx_we),
        .i_waddr (r_rx_wa),
        .i_wdata (r_data),
        .i_re    (w_rd_en),
        .i_raddr (r_rx_ra),
        .o_rdata (w_rx_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_can_load = !r_ovalid || i_out_ready;
    assign w_rd_en    = (r_state == S_READ);
    assign w_load     = (r_state == S_EXEC) && w_can_load;

    assign w_tx_free  = TCW'(TX_DEPTH) - r_tx_cnt;
    assign w_burst_ok = (r_len != 5'd0) && (TCMW'(r_len) <= TCMW'(TX_DEPTH))
                        && (TCMW'(w_tx_free) >= TCMW'(r_len));
    assign w_bread_ok = (r_len != 5'd0) && (r_len <= 5'(MAX_BURST_READ))
                        && (RCMW'(r_rx_cnt) >= RCMW'(r_len));
    assign w_left     = r_bact ? r_bcnt : r_len;

    always_comb begin
        n_state    = r_state;
        n_tx_wa    = r_tx_wa;
        n_tx_ra    = r_tx_ra;
        n_rx_wa    = r_rx_wa;
        n_rx_ra    = r_rx_ra;
        n_tx_cnt   = r_tx_cnt;
        n_rx_cnt   = r_rx_cnt;
        n_idle     = r_idle;
        n_ba       = r_ba;
        n_bl       = r_bl;
        n_bact     = r_bact;
        n_bcnt     = r_bcnt;
        n_sent     = r_sent;
        n_recv     = r_recv;
        n_err      = r_err;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_o_status = 1'b0;
        n_o_rbyte  = 8'd0;
        n_o_sv     = 1'b0;
        n_o_sb     = 8'd0;
        n_o_last   = 1'b1;
        w_tx_we    = 1'b0;
        w_rx_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_can_load) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                    case (r_op)
                        OP_FLUSH: begin
                            n_tx_wa  = '0;
                            n_tx_ra  = '0;
                            n_rx_wa  = '0;
                            n_rx_ra  = '0;
                            n_tx_cnt = '0;
                            n_rx_cnt = '0;
                            n_idle   = 1'b1;
                            n_ba     = 1'b0;
                            n_bl     = 5'd0;
                        end
                        OP_TX_PUT: begin
                            if (r_tx_cnt != TCW'(TX_DEPTH)) begin
                                w_tx_we  = 1'b1;
                                n_tx_wa  = (r_tx_wa == TAW'(TX_DEPTH - 1)) ? '0
                                           : r_tx_wa + 1'b1;
                                n_tx_cnt = r_tx_cnt + 1'b1;
                                n_idle   = 1'b0;
                            end else begin
                                n_o_status = 1'b1;
                            end
                        end
                        OP_TX_BURST: begin
                            // acceptance of the whole burst is settled on its first byte
                            if (r_first) begin
                                n_ba = w_burst_ok;
                                n_bl = w_burst_ok ? r_len : 5'd0;
                            end
                            if (n_ba && (n_bl != 5'd0)) begin
                                w_tx_we  = 1'b1;
                                n_tx_wa  = (r_tx_wa == TAW'(TX_DEPTH - 1)) ? '0
                                           : r_tx_wa + 1'b1;
                                n_tx_cnt = r_tx_cnt + 1'b1;
                                n_idle   = 1'b0;
                                n_bl     = n_bl - 5'd1;
                                if (n_bl == 5'd0) begin
                                    n_ba = 1'b0;
                                end
                            end else begin
                                n_o_status = 1'b1;
                            end
                        end
                        OP_RX_GET: begin
                            if (r_rx_cnt != '0) begin
                                n_o_rbyte = w_rx_rdata;
                                n_rx_ra   = (r_rx_ra == RAW'(RX_DEPTH - 1)) ? '0
                                            : r_rx_ra + 1'b1;
                                n_rx_cnt  = r_rx_cnt - 1'b1;
                            end else begin
                                n_o_status = 1'b1;
                            end
                        end
                        OP_RX_BURST: begin
                            if (!r_bact && !w_bread_ok) begin
                                n_o_status = 1'b1;
                            end else begin
                                n_o_rbyte = w_rx_rdata;
                                n_rx_ra   = (r_rx_ra == RAW'(RX_DEPTH - 1)) ? '0
                                            : r_rx_ra + 1'b1;
                                n_rx_cnt  = r_rx_cnt - 1'b1;
                                if (w_left == 5'd1) begin
                                    n_bact = 1'b0;
                                end else begin
                                    // more bytes to go: read the next entry
                                    n_o_last = 1'b0;
                                    n_bact   = 1'b1;
                                    n_bcnt   = w_left - 5'd1;
                                    n_state  = S_READ;
                                end
                            end
                        end
                        OP_SERVICE: begin
                            if (r_txe) begin
                                if (r_tx_cnt != '0) begin
                                    n_o_sv   = 1'b1;
                                    n_o_sb   = w_tx_rdata;
                                    n_tx_ra  = (r_tx_ra == TAW'(TX_DEPTH - 1)) ? '0
                                               : r_tx_ra + 1'b1;
                                    n_tx_cnt = r_tx_cnt - 1'b1;
                                    n_idle   = 1'b0;
                                    n_sent   = r_sent + 32'd1;
                                end else begin
                                    n_idle = 1'b1;
                                end
                            end
                            if (r_rxr && (r_rx_cnt != RCW'(RX_DEPTH))) begin
                                w_rx_we  = 1'b1;
                                n_rx_wa  = (r_rx_wa == RAW'(RX_DEPTH - 1)) ? '0
                                           : r_rx_wa + 1'b1;
                                n_rx_cnt = r_rx_cnt + 1'b1;
                                n_recv   = r_recv + 32'd1;
                            end
                            if (r_lerr) begin
                                n_err = r_err + 32'd1;
                            end
                        end
                        default: begin
                            n_o_status = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tx_wa  <= '0;
            r_tx_ra  <= '0;
            r_rx_wa  <= '0;
            r_rx_ra  <= '0;
            r_tx_cnt <= '0;
            r_rx_cnt <= '0;
            r_idle   <= 1'b1;
            r_ba     <= 1'b0;
            r_bl     <= 5'd0;
            r_bact   <= 1'b0;
            r_bcnt   <= 5'd0;
            r_sent   <= 32'd0;
            r_recv   <= 32'd0;
            r_err    <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tx_wa  <= n_tx_wa;
            r_tx_ra  <= n_tx_ra;
            r_rx_wa  <= n_rx_wa;
            r_rx_ra  <= n_rx_ra;
            r_tx_cnt <= n_tx_cnt;
            r_rx_cnt <= n_rx_cnt;
            r_idle   <= n_idle;
            r_ba     <= n_ba;
            r_bl     <= n_bl;
            r_bact   <= n_bact;
            r_bcnt   <= n_bcnt;
            r_sent   <= n_sent;
            r_recv   <= n_recv;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_opcode;
            r_data  <= i_data;
            r_len   <= i_burst_length;
            r_first <= i_burst_first;
            r_txe   <= i_tx_empty;
            r_rxr   <= i_rx_ready;
            r_lerr  <= (i_line_errors != 4'd0);
        end
        if (w_load) begin
            r_o_status       <= n_o_status;
            r_o_rbyte        <= n_o_rbyte;
            r_o_sv           <= n_o_sv;
            r_o_sb           <= n_o_sb;
            r_o_last         <= n_o_last;
            o_tx_irq_on      <= !n_idle;
            o_tx_level       <= 5'(n_tx_cnt);
            o_rx_level       <= 5'(n_rx_cnt);
            o_sent_total     <= n_sent;
            o_received_total <= n_recv;
            o_error_total    <= n_err;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_o_status;
    assign o_read_byte  = r_o_rbyte;
    assign o_send_valid = r_o_sv;
    assign o_send_byte  = r_o_sb;
    assign o_last       = r_o_last;

endmodule
